/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pbp_pkg.sv */
// ----------------------------------------------------------------------------
// Policy blob parser package
// Entry kinds, body lengths, result codes and the result record type.
// ----------------------------------------------------------------------------
`default_nettype none

package pbp_pkg;

  localparam logic [7:0] DEFAULT_VERSION  = 8'd1;
  localparam logic [7:0] KIND_CFG         = 8'd1;
  localparam logic [7:0] KIND_ASSOC       = 8'd2;
  localparam logic [7:0] KIND_WAKE        = 8'd3;
  localparam int         CFG_BODY_BYTES   = 7;
  localparam int         ASSOC_HEAD_BYTES = 2;
  localparam int         WAKE_BODY_BYTES  = 5;

  localparam logic [2:0] REG_EXPECTED_VERSION = 3'd0;

  localparam int         FIFO_DEPTH          = 4;
  localparam int         PTR_W               = $clog2(FIFO_DEPTH);
  localparam int         CNT_W               = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_CONFIG = 3'd0,
    EV_GROUP  = 3'd1,
    EV_MEMBER = 3'd2,
    EV_WAKE   = 3'd3,
    EV_ACCEPT = 3'd4,
    EV_REJECT = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_SHORT   = 3'd1,
    ERR_VERSION = 3'd2,
    ERR_TRUNC   = 3'd3,
    ERR_KIND    = 3'd4
  } err_t;

  typedef struct packed {
    event_t      ev;
    logic [7:0]  key;
    logic [7:0]  size;
    logic        sgn;
    logic [31:0] word;
    logic [7:0]  node;
    logic [7:0]  total;
    err_t        err;
    logic        last;
  } res_t;

  function automatic res_t make_res(event_t ev, logic [7:0] key, logic [7:0] size,
                                    logic sgn, logic [31:0] word, logic [7:0] node,
                                    logic [7:0] total, err_t err);
    res_t r;
    r.ev    = ev;
    r.key   = key;
    r.size  = size;
    r.sgn   = sgn;
    r.word  = word;
    r.node  = node;
    r.total = total;
    r.err   = err;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/policy_blob_parser.sv */
// ----------------------------------------------------------------------------
// Policy blob parser: one blob byte per cycle while ready, records out via a queue.
// Records are registered in the queue when their byte is taken and leave it in order.
// Input ready needs two free slots; a byte causing two records takes two queue slots.
// Reset: synchronous; state, queue and expected_version (to 1) are restored.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module policy_blob_parser
  import pbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // s_axis_tdata: data_byte[7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // m_axis_tdata: entry_key[7:0], value_size[15:8], value_signed[16],
  // word_value[48:17], node_id[56:49], member_total[64:57], fault_code[67:65]
  output logic [71:0]      m_axis_tdata,
  // m_axis_tuser: event_res[2:0]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [2:0] {
    PH_VERSION = 3'd0,
    PH_COUNT   = 3'd1,
    PH_KIND    = 3'd2,
    PH_CONFIG  = 3'd3,
    PH_ASSOC   = 3'd4,
    PH_MEMBERS = 3'd5,
    PH_WAKE    = 3'd6,
    PH_IGNORE  = 3'd7
  } phase_t;

  logic [7:0]  expected_version;
  phase_t      phase, phase_next;
  logic [7:0]  entries_left, entries_left_next;
  logic [2:0]  body_pos, body_pos_next;
  logic [7:0]  members_left, members_left_next;
  logic [7:0]  held_key, held_key_next;
  logic [7:0]  held_size, held_size_next;
  logic        held_signed, held_signed_next;
  logic [31:0] word_acc, word_acc_next;

  res_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] cnt;

  res_t res_a, res_b;
  logic a_valid, b_valid, entry_done;
  logic in_fire, out_fire;
  logic [7:0] b;
  res_t head_res;

  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_EXPECTED_VERSION[2]) ?
                         {24'd0, expected_version} : 32'd0;
  assign s_axis_tready = (cnt <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (cnt != '0);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign b             = s_axis_tdata;

  assign head_res     = fifo[head];
  assign m_axis_tdata = {4'd0, head_res.err, head_res.total, head_res.node, head_res.word,
                         head_res.sgn, head_res.size, head_res.key};
  assign m_axis_tuser = head_res.ev;
  assign m_axis_tlast = head_res.last;

  always_comb begin
    phase_next        = phase;
    entries_left_next = entries_left;
    body_pos_next     = body_pos;
    members_left_next = members_left;
    held_key_next     = held_key;
    held_size_next    = held_size;
    held_signed_next  = held_signed;
    word_acc_next     = word_acc;
    res_a             = '0;
    res_b             = '0;
    a_valid           = 1'b0;
    b_valid           = 1'b0;
    entry_done        = 1'b0;

    unique case (phase)
      PH_VERSION: begin
        if (s_axis_tlast) begin
          res_a   = make_res(EV_REJECT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_SHORT);
          a_valid = 1'b1;
        end else if (b != expected_version) begin
          res_a      = make_res(EV_REJECT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_VERSION);
          a_valid    = 1'b1;
          phase_next = PH_IGNORE;
        end else begin
          phase_next = PH_COUNT;
        end
      end
      PH_COUNT: begin
        entries_left_next = b;
        if (b == 8'd0) begin
          res_a      = make_res(EV_ACCEPT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_NONE);
          a_valid    = 1'b1;
          phase_next = PH_IGNORE;
        end else begin
          phase_next = PH_KIND;
        end
      end
      PH_KIND: begin
        body_pos_next = 3'd0;
        if (b == KIND_CFG) begin
          phase_next = PH_CONFIG;
        end else if (b == KIND_ASSOC) begin
          phase_next = PH_ASSOC;
        end else if (b == KIND_WAKE) begin
          phase_next = PH_WAKE;
        end else begin
          res_a      = make_res(EV_REJECT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_KIND);
          a_valid    = 1'b1;
          phase_next = PH_IGNORE;
        end
      end
      PH_CONFIG: begin
        if (body_pos == 3'd0) begin
          held_key_next = b;
        end else if (body_pos == 3'd1) begin
          held_size_next = b;
        end else if (body_pos == 3'd2) begin
          held_signed_next = (b != 8'd0);
        end else if (body_pos == 3'd3) begin
          word_acc_next = {24'd0, b};
        end else begin
          word_acc_next = {word_acc[23:0], b};
        end
        body_pos_next = body_pos + 3'd1;
        if (body_pos == 3'(CFG_BODY_BYTES - 1)) begin
          body_pos_next = 3'd0;
          res_a      = make_res(EV_CONFIG, held_key, held_size, held_signed,
                                {word_acc[23:0], b}, 8'd0, 8'd0, ERR_NONE);
          a_valid    = 1'b1;
          entry_done = 1'b1;
        end
      end
      PH_ASSOC: begin
        if (body_pos == 3'd0) begin
          held_key_next = b;
          body_pos_next = 3'd1;
        end else begin
          body_pos_next     = 3'd0;
          members_left_next = b;
          res_a   = make_res(EV_GROUP, held_key, 8'd0, 1'b0, 32'd0, 8'd0, b, ERR_NONE);
          a_valid = 1'b1;
          if (b == 8'd0) begin
            entry_done = 1'b1;
          end else begin
            phase_next = PH_MEMBERS;
          end
        end
      end
      PH_MEMBERS: begin
        res_a   = make_res(EV_MEMBER, held_key, 8'd0, 1'b0, 32'd0, b, 8'd0, ERR_NONE);
        a_valid = 1'b1;
        members_left_next = members_left - 8'd1;
        if (members_left_next == 8'd0) begin
          entry_done = 1'b1;
        end
      end
      PH_WAKE: begin
        if (body_pos == 3'd0) begin
          word_acc_next = {24'd0, b};
        end else if (body_pos < 3'(WAKE_BODY_BYTES - 1)) begin
          word_acc_next = {word_acc[23:0], b};
        end
        body_pos_next = body_pos + 3'd1;
        if (body_pos == 3'(WAKE_BODY_BYTES - 1)) begin
          body_pos_next = 3'd0;
          res_a      = make_res(EV_WAKE, 8'd0, 8'd0, 1'b0, word_acc, b, 8'd0, ERR_NONE);
          a_valid    = 1'b1;
          entry_done = 1'b1;
        end
      end
      PH_IGNORE: begin
      end
    endcase

    if (entry_done) begin
      entries_left_next = entries_left - 8'd1;
      if (entries_left_next == 8'd0) begin
        phase_next = PH_IGNORE;
        res_b      = make_res(EV_ACCEPT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_NONE);
        b_valid    = 1'b1;
      end else begin
        phase_next = PH_KIND;
      end
    end

    if (s_axis_tlast) begin
      if (phase_next != PH_IGNORE && phase_next != PH_VERSION) begin
        if (a_valid) begin
          res_b   = make_res(EV_REJECT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_TRUNC);
          b_valid = 1'b1;
        end else begin
          res_a   = make_res(EV_REJECT, 8'd0, 8'd0, 1'b0, 32'd0, 8'd0, 8'd0, ERR_TRUNC);
          a_valid = 1'b1;
        end
      end
      phase_next        = PH_VERSION;
      entries_left_next = 8'd0;
      body_pos_next     = 3'd0;
      members_left_next = 8'd0;
      held_key_next     = 8'd0;
      held_size_next    = 8'd0;
      held_signed_next  = 1'b0;
      word_acc_next     = 32'd0;
    end

    res_a.last = !b_valid;
    res_b.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= DEFAULT_VERSION;
      phase            <= PH_VERSION;
      entries_left     <= 8'd0;
      body_pos         <= 3'd0;
      members_left     <= 8'd0;
      held_key         <= 8'd0;
      held_size        <= 8'd0;
      held_signed      <= 1'b0;
      word_acc         <= 32'd0;
      head             <= '0;
      tail             <= '0;
      cnt              <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == REG_EXPECTED_VERSION[2])) begin
        expected_version <= pwdata[7:0];
      end
      if (in_fire) begin
        phase        <= phase_next;
        entries_left <= entries_left_next;
        body_pos     <= body_pos_next;
        members_left <= members_left_next;
        held_key     <= held_key_next;
        held_size    <= held_size_next;
        held_signed  <= held_signed_next;
        word_acc     <= word_acc_next;
        if (a_valid && b_valid) begin
          tail <= tail + PTR_W'(2);
        end else if (a_valid) begin
          tail <= tail + PTR_W'(1);
        end
      end
      if (out_fire) begin
        head <= head + PTR_W'(1);
      end
      cnt <= cnt + CNT_W'(in_fire && a_valid) + CNT_W'(in_fire && b_valid)
                 - CNT_W'(out_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && a_valid) begin
      fifo[tail] <= res_a;
    end
    if (in_fire && b_valid) begin
      fifo[tail + PTR_W'(1)] <= res_b;
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, cnt <= CNT_W'(FIFO_DEPTH),
                 "result queue overflow")
  `ASSERT_NEXT(a_final_resets, clk, rst, in_fire && s_axis_tlast, phase == PH_VERSION,
               "phase not cleared after final byte")
  `ASSERT_IMPLY(a_verdict_last, clk, rst,
                m_axis_tvalid && (m_axis_tuser == EV_ACCEPT || m_axis_tuser == EV_REJECT),
                m_axis_tlast, "verdict is not the last record of its byte")
  `ASSERT_IMPLY(a_err_on_reject, clk, rst, m_axis_tvalid && m_axis_tuser != EV_REJECT,
                m_axis_tdata[67:65] == 3'd0, "error code outside a reject")

endmodule

`default_nettype wire

/* bench/tb_policy_blob_parser.sv */
// ----------------------------------------------------------------------------
// Policy blob parser testbench
// Streams policy blobs into the parser one byte per request and predicts
// every record, accept and reject that each byte must produce. The output
// stream is compared field by field against the prediction. Directed blobs
// come first, then changes of the expected version, long output stalls and
// sender pauses, and last a long run of random blobs, most of them
// well-formed and the rest cut short, wrongly versioned or with bad kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_policy_blob_parser;
  import pbp_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RUN_LIMIT = 800000;
  localparam int RANDOM_BYTES = 850;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [3:0] {
    AWAIT_VERSION,
    AWAIT_COUNT,
    AWAIT_KIND,
    IN_CONFIG,
    IN_GROUP_HEAD,
    IN_MEMBERS,
    IN_WAKEUP,
    SKIP_REST
  } phase_t;

  typedef struct {
    event_t      ev;
    logic [7:0]  key;
    logic [7:0]  size;
    logic        sgn;
    logic [31:0] word;
    logic [7:0]  node;
    logic [7:0]  total;
    err_t        err;
    logic        last;
  } record_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // s_axis_tdata: data_byte[7:0]
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // m_axis_tdata: entry_key[7:0], value_size[15:8], value_signed[16],
  // word_value[48:17], node_id[56:49], member_total[64:57], fault_code[67:65]
  logic [71:0] m_axis_tdata;
  // m_axis_tuser: event_res[2:0]
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  phase_t      phase;
  logic [7:0]  entries_left;
  logic [2:0]  body_pos;
  logic [7:0]  members_left;
  logic [7:0]  held_key;
  logic [7:0]  held_size;
  logic        held_sgn;
  logic [31:0] word_acc;
  logic [7:0]  version_reg;

  record_t     pending_records[$];
  record_t     step_out[$];
  logic [7:0]  blob_bytes[$];

  int          fail_count;
  int          cycle_count;
  int          sink_hold_cycles;
  bit          src_gaps_on;
  bit          sink_gaps_on;

  policy_blob_parser dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic record_t blank(event_t ev);
    record_t r;
    r.ev    = ev;
    r.key   = '0;
    r.size  = '0;
    r.sgn   = 1'b0;
    r.word  = '0;
    r.node  = '0;
    r.total = '0;
    r.err   = ERR_NONE;
    r.last  = 1'b0;
    return r;
  endfunction

  function automatic record_t verdict(event_t ev, err_t code);
    record_t r;
    r = blank(ev);
    r.err = code;
    return r;
  endfunction

  task automatic add_rec(input record_t r);
    step_out.insert(step_out.size(), r);
  endtask

  task automatic put_byte(input logic [7:0] v);
    blob_bytes.insert(blob_bytes.size(), v);
  endtask

  task automatic clear_parse();
    phase        = AWAIT_VERSION;
    entries_left = '0;
    body_pos     = '0;
    members_left = '0;
    held_key     = '0;
    held_size    = '0;
    held_sgn     = 1'b0;
    word_acc     = '0;
  endtask

  task automatic close_entry();
    entries_left = entries_left - 8'd1;
    if (entries_left == 8'd0) begin
      phase = SKIP_REST;
      add_rec(verdict(EV_ACCEPT, ERR_NONE));
    end else begin
      phase = AWAIT_KIND;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    record_t r;
    step_out.delete();
    case (phase)
      AWAIT_VERSION: begin
        if (fin) begin
          add_rec(verdict(EV_REJECT, ERR_SHORT));
        end else if (b != version_reg) begin
          add_rec(verdict(EV_REJECT, ERR_VERSION));
          phase = SKIP_REST;
        end else begin
          phase = AWAIT_COUNT;
        end
      end
      AWAIT_COUNT: begin
        entries_left = b;
        if (b == 8'd0) begin
          add_rec(verdict(EV_ACCEPT, ERR_NONE));
          phase = SKIP_REST;
        end else begin
          phase = AWAIT_KIND;
        end
      end
      AWAIT_KIND: begin
        body_pos = '0;
        if (b == KIND_CFG) begin
          phase = IN_CONFIG;
        end else if (b == KIND_ASSOC) begin
          phase = IN_GROUP_HEAD;
        end else if (b == KIND_WAKE) begin
          phase = IN_WAKEUP;
        end else begin
          add_rec(verdict(EV_REJECT, ERR_KIND));
          phase = SKIP_REST;
        end
      end
      IN_CONFIG: begin
        case (body_pos)
          3'd0: held_key = b;
          3'd1: held_size = b;
          3'd2: held_sgn = (b != 8'd0);
          3'd3: word_acc = {24'd0, b};
          default: word_acc = {word_acc[23:0], b};
        endcase
        body_pos = body_pos + 3'd1;
        if (body_pos == CFG_BODY_BYTES) begin
          body_pos = '0;
          r = blank(EV_CONFIG);
          r.key  = held_key;
          r.size = held_size;
          r.sgn  = held_sgn;
          r.word = word_acc;
          add_rec(r);
          close_entry();
        end
      end
      IN_GROUP_HEAD: begin
        if (body_pos == 3'd0) begin
          held_key = b;
          body_pos = 3'd1;
        end else begin
          body_pos = '0;
          members_left = b;
          r = blank(EV_GROUP);
          r.key   = held_key;
          r.total = b;
          add_rec(r);
          if (b == 8'd0) close_entry();
          else phase = IN_MEMBERS;
        end
      end
      IN_MEMBERS: begin
        r = blank(EV_MEMBER);
        r.key  = held_key;
        r.node = b;
        add_rec(r);
        members_left = members_left - 8'd1;
        if (members_left == 8'd0) close_entry();
      end
      IN_WAKEUP: begin
        if (body_pos == 3'd0) word_acc = {24'd0, b};
        else if (body_pos < WAKE_BODY_BYTES - 1) word_acc = {word_acc[23:0], b};
        body_pos = body_pos + 3'd1;
        if (body_pos == WAKE_BODY_BYTES) begin
          body_pos = '0;
          r = blank(EV_WAKE);
          r.word = word_acc;
          r.node = b;
          add_rec(r);
          close_entry();
        end
      end
      default: ;
    endcase
    if (fin) begin
      if (phase != SKIP_REST && phase != AWAIT_VERSION)
        add_rec(verdict(EV_REJECT, ERR_TRUNC));
      clear_parse();
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) pending_records.insert(pending_records.size(), step_out[i]);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    record_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_records.size() == 0) begin
          $error("result with no request pending: event_res %0d", m_axis_tuser);
          fail_count++;
        end else begin
          want = pending_records.pop_front();
          check_field("event_res", want.ev, m_axis_tuser);
          check_field("entry_key", want.key, m_axis_tdata[7:0]);
          check_field("value_size", want.size, m_axis_tdata[15:8]);
          check_field("value_signed", want.sgn, m_axis_tdata[16]);
          check_field("word_value", want.word, m_axis_tdata[48:17]);
          check_field("node_id", want.node, m_axis_tdata[56:49]);
          check_field("member_total", want.total, m_axis_tdata[64:57]);
          check_field("fault_code", want.err, m_axis_tdata[67:65]);
          check_field("run_end", want.last, m_axis_tlast);
        end
      end
      if (psel && penable && pwrite && pready && paddr == REG_EXPECTED_VERSION)
        version_reg = pwdata[7:0];
      if (s_axis_tvalid && s_axis_tready)
        decode_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  initial begin : sink
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold_cycles--;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap(sink_gaps_on);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Returns just after the edge that accepted the request; tvalid stays
  // high until the next send or stop_source.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap(src_gaps_on);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic stop_source();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_blob();
    foreach (blob_bytes[i]) send_byte(blob_bytes[i], i == blob_bytes.size() - 1);
  endtask

  task automatic wait_drained();
    stop_source();
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_version(input logic [7:0] v);
    logic [31:0] rd;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    apb_write(REG_EXPECTED_VERSION, {24'd0, v});
    apb_read(REG_EXPECTED_VERSION, rd);
    check_field("expected_version", {24'd0, version_reg}, rd);
  endtask

  // Builds one blob into blob_bytes.
  task automatic build_blob();
    int n_entries, members, mode, r, at;
    int kind_at[$];
    logic [7:0] bad_kind;
    blob_bytes.delete();
    put_byte(version_reg);
    n_entries = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5);
    put_byte(8'(n_entries));
    repeat (n_entries) begin
      kind_at.insert(kind_at.size(), blob_bytes.size());
      case ($urandom_range(0, 2))
        0: begin
          put_byte(KIND_CFG);
          put_byte(any_byte());
          put_byte(any_byte());
          put_byte($urandom_range(0, 1) ? 8'd0 : any_byte());
          repeat (4) put_byte(any_byte());
        end
        1: begin
          put_byte(KIND_ASSOC);
          put_byte(any_byte());
          r = $urandom_range(0, 99);
          if (r < 10) members = 0;
          else if (r < 97) members = $urandom_range(1, 5);
          else members = $urandom_range(100, 255);
          put_byte(8'(members));
          repeat (members) put_byte(any_byte());
        end
        default: begin
          put_byte(KIND_WAKE);
          repeat (5) put_byte(any_byte());
        end
      endcase
    end
    mode = $urandom_range(0, 9);
    if (mode == 7) begin
      if (blob_bytes.size() > 2 && $urandom_range(0, 1)) blob_bytes[1] = any_byte();
      at = $urandom_range(1, blob_bytes.size());
      while (blob_bytes.size() > at) void'(blob_bytes.pop_back());
    end else if (mode == 8) begin
      blob_bytes[0] = version_reg ^ 8'($urandom_range(1, 255));
    end else if (mode == 9 && n_entries > 0) begin
      at = kind_at[$urandom_range(0, kind_at.size() - 1)];
      bad_kind = 8'($urandom_range(0, 252));
      if (bad_kind >= 8'd1) bad_kind = bad_kind + 8'd3;
      blob_bytes[at] = bad_kind;
    end else begin
      repeat ($urandom_range(0, 2)) put_byte(any_byte());
    end
  endtask

  task automatic test_reset_value();
    logic [31:0] rd;
    apb_read(REG_EXPECTED_VERSION, rd);
    check_field("expected_version", {24'd0, DEFAULT_VERSION}, rd);
  endtask

  task automatic test_directed_blobs();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    blob_bytes = '{8'h01};
    send_blob();
    blob_bytes = '{8'h00, 8'h02};
    send_blob();
    blob_bytes = '{8'h01, 8'h00};
    send_blob();
    blob_bytes = '{8'h01, 8'h01, KIND_CFG, 8'hFF, 8'h04, 8'h80,
                   8'hFF, 8'h00, 8'h00, 8'h01};
    send_blob();
    blob_bytes = '{8'h01, 8'h01, 8'hFF};
    send_blob();
    blob_bytes = '{8'h01, 8'h01, KIND_ASSOC, 8'h05, 8'h02, 8'h11};
    send_blob();
  endtask

  task automatic test_version_setting();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    set_version(8'h00);
    blob_bytes = '{8'h00, 8'h01, KIND_WAKE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_blob();
    blob_bytes = '{8'h01, 8'h00};
    send_blob();
    set_version(8'hFF);
    blob_bytes = '{8'hFF, 8'h00, 8'h33};
    send_blob();
    blob_bytes = '{8'hFE, 8'h00};
    send_blob();
    set_version(8'($urandom_range(0, 255)));
    blob_bytes = '{version_reg, 8'h00};
    send_blob();
    set_version(DEFAULT_VERSION);
  endtask

  task automatic test_backpressure();
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    sink_hold_cycles = 300;
    blob_bytes = '{8'h01, 8'h01, KIND_ASSOC, 8'h5A, 8'd40};
    for (int i = 0; i < 40; i++) put_byte(8'(i * 6 + 1));
    send_blob();
  endtask

  task automatic test_drain_pause();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(KIND_WAKE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h0E, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h2A, 1'b0);
    wait_drained();
    send_byte(KIND_ASSOC, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_blobs();
    int sent, blobs;
    sent  = 0;
    blobs = 0;
    while (sent < RANDOM_BYTES) begin
      if (blobs % 40 == 39) begin
        case ($urandom_range(0, 3))
          0: set_version(8'h00);
          1: set_version(8'hFF);
          2: set_version(8'($urandom_range(0, 255)));
          default: set_version(DEFAULT_VERSION);
        endcase
      end
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      build_blob();
      send_blob();
      sent += blob_bytes.size();
      blobs++;
    end
  endtask

  initial begin
    rst              = 1'b1;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tlast     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    sink_hold_cycles = 0;
    src_gaps_on      = 1'b0;
    sink_gaps_on     = 1'b0;
    fail_count       = 0;
    version_reg      = DEFAULT_VERSION;
    clear_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_value();
    test_directed_blobs();
    test_version_setting();
    test_backpressure();
    test_drain_pause();
    test_random_blobs();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
